>>> rtl/core/ordered_list_move_by_offset_assert.svh
// Assertion macros for the ordered list move-by-offset block
`ifndef ORDERED_LIST_MOVE_BY_OFFSET_ASSERT_SVH
`define ORDERED_LIST_MOVE_BY_OFFSET_ASSERT_SVH
`ifndef ASSERT_OFF
`define OLM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("olm: same-cycle check failed");
`define OLM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("olm: next-cycle check failed");
`else
`define OLM_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define OLM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/olm_pkg.sv
// Shared types, field widths and codes of the ordered list block
package olm_pkg;

    localparam int ID_W  = 11;
    localparam int OFF_W = 11;
    localparam int POS_W = 10;

    typedef logic [ID_W-1:0]         id_t;
    typedef logic signed [OFF_W-1:0] offset_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic                    opcode_t;

    localparam opcode_t OP_MOVE = 1'b0;
    localparam opcode_t OP_READ = 1'b1;

    localparam id_t QLEN_RESET = 11'd1024;

    typedef struct packed {
        pos_t new_position;
        id_t  read_id;
        logic fault;
    } olm_result_t;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_RD_ISSUE = 9'b000000100,
        ST_RD_WAIT  = 9'b000001000,
        ST_SEARCH   = 9'b000010000,
        ST_CHECK    = 9'b000100000,
        ST_SHIFT    = 9'b001000000,
        ST_PLACE    = 9'b010000000,
        ST_REPLY    = 9'b100000000
    } olm_state_t;

endpackage

>>> rtl/core/olm_if.sv
// Request, response and configuration channel interfaces
interface olm_req_if;
    import olm_pkg::*;
    logic    valid;
    logic    ready;
    opcode_t opcode;
    id_t     item_id;
    offset_t offset;
    pos_t    read_position;
    modport source (output valid, opcode, item_id, offset, read_position, input ready);
    modport sink   (input valid, opcode, item_id, offset, read_position, output ready);
endinterface

interface olm_rsp_if;
    import olm_pkg::*;
    logic valid;
    logic ready;
    pos_t new_position;
    id_t  read_id;
    logic fault;
    modport source (output valid, new_position, read_id, fault, input ready);
    modport sink   (input valid, new_position, read_id, fault, output ready);
endinterface

interface olm_cfg_if;
    import olm_pkg::*;
    logic valid;
    logic ready;
    id_t  queue_length;
    modport source (output valid, queue_length, input ready);
    modport sink   (input valid, queue_length, output ready);
endinterface

>>> rtl/core/olm_store.sv
// List store: one write port and one registered read port
module olm_store #(
    parameter int MAX_ENTRIES = 1024,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  olm_pkg::id_t  wdata,
    input  logic [AW-1:0] raddr,
    output olm_pkg::id_t  rdata
);
    import olm_pkg::*;

    id_t mem_reg [MAX_ENTRIES];
    id_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/olm_seq.sv
// Sequencer: clear sweep, position reads, search, shift walk and placement over the list store
module olm_seq #(
    parameter int MAX_ENTRIES = 1024,
    localparam int AW = $clog2(MAX_ENTRIES),
    localparam int LW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    olm_req_if.sink              req,
    input  logic [LW-1:0]        len,
    input  logic                 slot_free,
    output logic                 done,
    output olm_pkg::olm_result_t result,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output olm_pkg::id_t         mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  olm_pkg::id_t         mem_rdata
);
    import olm_pkg::*;

    localparam int CW = ((LW > ID_W) ? LW : ID_W) + 1;
    localparam int SW = CW + 1;

    olm_state_t  state_reg, state_next;
    logic [LW-1:0] ctr_reg, ctr_next;
    logic        look_reg, look_next;
    logic        pend_reg, pend_next;
    logic [LW-1:0] dest_reg, dest_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] t_reg, t_next;
    logic        up_reg, up_next;
    id_t         id_reg, id_next;
    offset_t     off_reg, off_next;
    pos_t        rp_reg, rp_next;
    olm_result_t res_reg, res_next;

    logic [SW-1:0] tgt;
    logic [LW-1:0] step;

    assign tgt  = {{(SW - LW){1'b0}}, p_reg} + {{(SW - OFF_W){off_reg[OFF_W-1]}}, off_reg};
    assign step = up_reg ? ctr_reg + LW'(1) : ctr_reg - LW'(1);

    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        look_next  = look_reg;
        pend_next  = pend_reg;
        dest_next  = dest_reg;
        p_next     = p_reg;
        t_next     = t_reg;
        up_next    = up_reg;
        id_next    = id_reg;
        off_next   = off_reg;
        rp_next    = rp_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = ctr_reg[AW-1:0];
        mem_wdata  = id_reg;
        mem_raddr  = ctr_reg[AW-1:0];
        req.ready  = 1'b0;
        done       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = ID_W'(ctr_reg + LW'(1));
                if (ctr_reg == LW'(MAX_ENTRIES - 1))
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctr_next = ctr_reg + LW'(1);
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    id_next   = req.item_id;
                    off_next  = req.offset;
                    rp_next   = req.read_position;
                    res_next  = '0;
                    ctr_next  = '0;
                    look_next = 1'b0;
                    state_next = (req.opcode == OP_READ) ? ST_RD_ISSUE : ST_SEARCH;
                end
            end
            ST_RD_ISSUE:
            begin
                mem_raddr = AW'(rp_reg);
                if (CW'(rp_reg) < CW'(len))
                begin
                    state_next = ST_RD_WAIT;
                end
                else
                begin
                    res_next.fault = 1'b1;
                    state_next     = ST_REPLY;
                end
            end
            ST_RD_WAIT:
            begin
                res_next.read_id = mem_rdata;
                state_next       = ST_REPLY;
            end
            ST_SEARCH:
            begin
                if (look_reg && (mem_rdata == id_reg))
                begin
                    p_next     = dest_reg;
                    state_next = ST_CHECK;
                end
                else if (ctr_reg < len)
                begin
                    look_next = 1'b1;
                    dest_next = ctr_reg;
                    ctr_next  = ctr_reg + LW'(1);
                end
                else
                begin
                    res_next.fault = 1'b1;
                    state_next     = ST_REPLY;
                end
            end
            ST_CHECK:
            begin
                if (tgt[SW-1] || (tgt[CW-1:0] >= CW'(len)))
                begin
                    res_next.fault = 1'b1;
                    state_next     = ST_REPLY;
                end
                else
                begin
                    t_next     = tgt[LW-1:0];
                    up_next    = tgt[CW-1:0] > CW'(p_reg);
                    ctr_next   = p_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // write the entry fetched last cycle, fetch the next one
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dest_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (ctr_reg != t_reg)
                begin
                    mem_raddr = step[AW-1:0];
                    pend_next = 1'b1;
                    dest_next = ctr_reg;
                    ctr_next  = step;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = t_reg[AW-1:0];
                mem_wdata = id_reg;
                res_next.new_position = POS_W'(t_reg);
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ctr_reg   <= '0;
            look_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            look_reg  <= look_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        p_reg    <= p_next;
        t_reg    <= t_next;
        up_reg   <= up_next;
        id_reg   <= id_next;
        off_reg  <= off_next;
        rp_reg   <= rp_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule

>>> rtl/core/ordered_list_move_by_offset.sv
// Top level of the ordered list move-by-offset block
// Keeps an ordered list of identifiers in a single-port-write, single-port-read
// store of MAX_ENTRIES entries. After reset the block sweeps the store, one
// entry a cycle, before it takes its first request; configuration writes are
// taken during the sweep. A read request fetches the entry at its position, or
// faults when the position is beyond the list length. A move request walks the
// store one entry a cycle: it searches for the identifier, checks the target
// range, slides the passed entries, places the identifier and replies; a
// target out of range or a miss ends in a fault reply. The block takes one
// request at a time; a finished result waits in the output register while the
// next request is accepted.
`include "ordered_list_move_by_offset_assert.svh"
module ordered_list_move_by_offset #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    olm_req_if.sink    req,
    olm_rsp_if.source  rsp,
    olm_cfg_if.sink    cfg
);
    import olm_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = ((LW > ID_W) ? LW : ID_W) + 1;

    id_t           qlen_reg;
    logic [LW-1:0] len;
    logic          rsp_valid_reg;
    olm_result_t   rsp_data_reg;
    logic          slot_free;
    logic          seq_done;
    olm_result_t   seq_result;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    id_t           mem_wdata;
    logic [AW-1:0] mem_raddr;
    id_t           mem_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= QLEN_RESET;
        end
        else if (cfg.valid)
        begin
            qlen_reg <= cfg.queue_length;
        end
    end

    // clamp the configured length to the store depth
    always_comb
    begin
        if (CW'(qlen_reg) > CW'(MAX_ENTRIES))
        begin
            len = LW'(MAX_ENTRIES);
        end
        else
        begin
            len = LW'(qlen_reg);
        end
    end

    olm_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    olm_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .len       (len),
        .slot_free (slot_free),
        .done      (seq_done),
        .result    (seq_result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign slot_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (seq_done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            rsp_data_reg <= seq_result;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.new_position = rsp_data_reg.new_position;
    assign rsp.read_id      = rsp_data_reg.read_id;
    assign rsp.fault        = rsp_data_reg.fault;

    `OLM_ASSERT_IMPL(a_fault_clears_fields, clk, rst_n, rsp.valid && rsp.fault, rsp.new_position == '0 && rsp.read_id == '0)
    `OLM_ASSERT_IMPL(a_read_has_no_position, clk, rst_n, rsp.valid && rsp.read_id != '0, rsp.new_position == '0)
    `OLM_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, seq_done, !rsp_valid_reg || rsp.ready)
    `OLM_ASSERT_NEXT(a_busy_after_request, clk, rst_n, req.valid && req.ready, !req.ready)

endmodule
